>>> hdl/assert_macros.svh
// Assertion macros shared by the comment stripper modules.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ccs_pkg.sv
// Package for the C comment stripper: lexer modes, character codes and the queue entry type.
// Used by every module of the block; depends on nothing.
package ccs_pkg;

    typedef enum logic [2:0] {
        MODE_CODE  = 3'd0,
        MODE_LINE  = 3'd1,
        MODE_BLOCK = 3'd2,
        MODE_STR   = 3'd3,
        MODE_CHR   = 3'd4
    } t_lex_mode;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic       pair;
        logic [7:0] first;
        logic [7:0] second;
    } t_entry;

endpackage

>>> hdl/ccs_front.sv
// Front end of the comment stripper: lexer state machine that classifies each input item.
// Produces a queue entry of one or two kept bytes; depends on ccs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ccs_front
    import ccs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_full,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_ready,
    output logic       o_push,
    output t_entry     o_entry
);

    t_lex_mode r_mode, n_mode;
    logic      r_esc, n_esc;
    logic      r_held, n_held;
    logic      r_star, n_star;
    logic [1:0] w_cnt;
    logic      w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CODE;
            r_esc  <= 1'b0;
            r_held <= 1'b0;
            r_star <= 1'b0;
        end else if (w_accept) begin
            r_mode <= n_mode;
            r_esc  <= n_esc;
            r_held <= n_held;
            r_star <= n_star;
        end
    end

    always_comb begin
        n_mode         = r_mode;
        n_esc          = r_esc;
        n_held         = r_held;
        n_star         = r_star;
        w_cnt          = 2'd0;
        o_entry.first  = i_byte;
        o_entry.second = i_byte;
        case (r_mode)
            MODE_LINE: begin
                if (i_byte == CH_NL) begin
                    n_mode = MODE_CODE;
                    w_cnt  = 2'd1;
                end
            end
            MODE_BLOCK: begin
                if (r_star && i_byte == CH_SLASH) begin
                    n_mode = MODE_CODE;
                    n_star = 1'b0;
                end else begin
                    n_star = (i_byte == CH_STAR);
                end
            end
            MODE_STR, MODE_CHR: begin
                w_cnt = 2'd1;
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if ((r_mode == MODE_STR && i_byte == CH_DQUOTE) ||
                             (r_mode == MODE_CHR && i_byte == CH_SQUOTE)) begin
                    n_mode = MODE_CODE;
                end else if (i_byte == CH_BSLASH) begin
                    n_esc = 1'b1;
                end
            end
            default: begin
                n_mode = MODE_CODE;
                if (r_held && i_byte == CH_SLASH) begin
                    n_held = 1'b0;
                    n_mode = MODE_LINE;
                end else if (r_held && i_byte == CH_STAR) begin
                    n_held = 1'b0;
                    n_mode = MODE_BLOCK;
                    n_star = 1'b0;
                end else if (!r_held && i_byte == CH_SLASH) begin
                    n_held = 1'b1;
                end else begin
                    n_held = 1'b0;
                    if (r_held) begin
                        w_cnt         = 2'd2;
                        o_entry.first = CH_SLASH;
                    end else begin
                        w_cnt = 2'd1;
                    end
                    if (i_byte == CH_SQUOTE) begin
                        n_mode = MODE_CHR;
                        n_esc  = 1'b0;
                    end else if (i_byte == CH_DQUOTE) begin
                        n_mode = MODE_STR;
                        n_esc  = 1'b0;
                    end
                end
            end
        endcase
        if (i_last) begin
            if (n_held && w_cnt == 2'd0) begin
                w_cnt         = 2'd1;
                o_entry.first = CH_SLASH;
            end
            n_mode = MODE_CODE;
            n_esc  = 1'b0;
            n_held = 1'b0;
            n_star = 1'b0;
        end
        o_entry.pair = (w_cnt == 2'd2);
    end

    assign o_push = w_accept && (w_cnt != 2'd0);

    `ASSERT_IMPLIES(a_held_only_in_code, r_held, r_mode == MODE_CODE, "Slash held outside code.")
    `ASSERT_IMPLIES(a_pair_needs_held, o_push && o_entry.pair,
        r_held && o_entry.first == CH_SLASH, "Two bytes emitted without a held slash.")

endmodule

>>> hdl/ccs_queue.sv
// Short queue between the lexer front end and the output back end of the comment stripper.
// Holds entries of one or two kept bytes; depends on ccs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ccs_queue
    import ccs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_IMPLIES(a_no_push_full, i_push, !o_full, "Push into a full queue.")
    `ASSERT_IMPLIES(a_no_pop_empty, i_pop, !o_empty, "Pop from an empty queue.")

endmodule

>>> hdl/ccs_back.sv
// Back end of the comment stripper: splits queue entries into single output bytes.
// Drives the registered output stream; depends on ccs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ccs_back
    import ccs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_entry     i_head,
    input  logic       i_ready,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_data,
    output logic       o_last
);

    logic       r_second;
    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       w_load;
    logic       w_take;
    logic       w_end;

    assign w_load = !r_valid || i_ready;
    assign w_take = w_load && !i_empty;
    assign w_end  = r_second || !i_head.pair;
    assign o_pop  = w_take && w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (w_load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_second <= !w_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data <= r_second ? i_head.second : i_head.first;
            r_last <= w_end;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

    `ASSERT_IMPLIES(a_second_needs_pair, r_second, !i_empty && i_head.pair,
        "Second byte pending without a two-byte entry.")
    `ASSERT_NEXT(a_second_then_last, w_take && r_second, r_valid && r_last,
        "Second byte of an entry not marked last.")

endmodule

>>> hdl/c_comment_stripper.sv
// Top level of the C comment stripper: front lexer, entry queue and output back end.
// Depends on ccs_pkg, ccs_front, ccs_queue and ccs_back.

// The block takes C source one byte per item and returns the text with line and block
// comments removed, passing string and character literals through with their escapes.
// It accepts one byte every cycle while its four-entry queue has room; the lexer state is
// updated in the same cycle. Each input byte yields zero, one or two output bytes, and
// the output register sends one byte per cycle while the receiver is ready, so a byte
// that releases a held slash adds an output byte that the queue absorbs. tlast on the
// output marks the last byte caused by one input byte.
module c_comment_stripper
    import ccs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast
);

    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;
    t_entry w_entry;
    t_entry w_head;

    ccs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_full  (w_full),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_ready (o_s_axis_tready),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    ccs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    ccs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .i_ready (i_m_axis_tready),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

>>> test/ccs_checker.sv
// Checker for the C comment stripper: watches both stream channels, predicts the kept bytes
// and compares every output item with the oldest prediction. Depends on ccs_pkg.
`timescale 1ns / 1ps

module ccs_checker
    import ccs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_data,
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_kept;

    t_kept     kept_q[$];
    t_lex_mode lex;
    logic      esc_pending;
    logic      slash_held;
    logic      star_seen;
    int        fails;
    int        checked;

    task automatic strip_byte(input logic [7:0] c, input logic fin);
        logic [7:0] outs [2];
        int         n;
        t_kept      k;
        n = 0;
        case (lex)
            MODE_LINE: begin
                if (c == CH_NL) begin
                    lex = MODE_CODE;
                    outs[n] = c;
                    n++;
                end
            end
            MODE_BLOCK: begin
                if (star_seen && c == CH_SLASH) begin
                    lex = MODE_CODE;
                    star_seen = 1'b0;
                end else begin
                    star_seen = (c == CH_STAR);
                end
            end
            MODE_STR, MODE_CHR: begin
                outs[n] = c;
                n++;
                if (esc_pending) begin
                    esc_pending = 1'b0;
                end else if (c == ((lex == MODE_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
                    lex = MODE_CODE;
                end else if (c == CH_BSLASH) begin
                    esc_pending = 1'b1;
                end
            end
            default: begin
                lex = MODE_CODE;
                if (slash_held && c == CH_SLASH) begin
                    slash_held = 1'b0;
                    lex = MODE_LINE;
                end else if (slash_held && c == CH_STAR) begin
                    slash_held = 1'b0;
                    lex = MODE_BLOCK;
                    star_seen = 1'b0;
                end else if (!slash_held && c == CH_SLASH) begin
                    slash_held = 1'b1;
                end else begin
                    if (slash_held) begin
                        outs[n] = CH_SLASH;
                        n++;
                        slash_held = 1'b0;
                    end
                    outs[n] = c;
                    n++;
                    if (c == CH_SQUOTE) begin
                        lex = MODE_CHR;
                        esc_pending = 1'b0;
                    end else if (c == CH_DQUOTE) begin
                        lex = MODE_STR;
                        esc_pending = 1'b0;
                    end
                end
            end
        endcase
        if (fin) begin
            if (slash_held && n < 2) begin
                outs[n] = CH_SLASH;
                n++;
            end
            lex = MODE_CODE;
            esc_pending = 1'b0;
            slash_held = 1'b0;
            star_seen = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            k.data = outs[i];
            k.last = (i == n - 1);
            kept_q.push_back(k);
        end
    endtask

    always @(posedge i_clk) begin
        t_kept k;
        if (!i_rst_n) begin
            kept_q.delete();
            lex = MODE_CODE;
            esc_pending = 1'b0;
            slash_held = 1'b0;
            star_seen = 1'b0;
            fails = 0;
            checked = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                strip_byte(i_in_data, i_in_last);
            end
            if (i_out_valid && i_out_ready) begin
                checked++;
                if (kept_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected output item: byte %02h last %0b",
                                 i_out_data, i_out_last);
                    end
                end else begin
                    k = kept_q.pop_front();
                    if (k.data !== i_out_data || k.last !== i_out_last) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                     k.data, k.last, i_out_data, i_out_last);
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= kept_q.size();
        o_checked <= checked;
    end

endmodule

>>> test/tb_top.sv
// Testbench top for the C comment stripper: clock, reset, byte stream stimulus and verdict.
// Depends on ccs_pkg, c_comment_stripper and ccs_checker.
`timescale 1ns / 1ps

module tb_top
    import ccs_pkg::*;
();

    localparam int ITEM_TARGET = 2000;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 10;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int         fail_count;
    int         pending;
    int         checked;
    int         cycles = 0;
    int         items_sent = 0;
    int         frames_sent = 0;
    int         hold_requests = 0;
    int         holds_started = 0;
    int         holds_served = 0;
    logic [7:0] frame_q[$];

    always #5 i_clk = ~i_clk;

    c_comment_stripper u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    ccs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_in_last    (s_tlast),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_out_last   (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d output items outstanding",
                     cycles, pending);
            $display("status: fail");
            $finish;
        end
    end

    // The output side mixes ready runs, short and long stalls, and long holds on request.
    initial begin
        int r;
        int run;
        forever begin
            if (holds_served != hold_requests) begin
                m_tready <= 1'b0;
                holds_started++;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_served++;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_tready <= 1'b1;
                    run = $urandom_range(1, 12);
                end else if (r < 62) begin
                    m_tready <= 1'b1;
                    run = $urandom_range(40, 120);
                end else if (r < 95) begin
                    m_tready <= 1'b0;
                    run = $urandom_range(1, 3);
                end else begin
                    m_tready <= 1'b0;
                    run = $urandom_range(15, 50);
                end
                repeat (run) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic fin, input bit gaps);
        int gap;
        gap = 0;
        if (gaps && $urandom_range(0, 99) < 30) begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= fin;
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_frame(input bit gaps);
        for (int i = 0; i < frame_q.size(); i++) begin
            send_item(frame_q[i], i == frame_q.size() - 1, gaps);
        end
        frame_q.delete();
        frames_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [7:0] code_char();
        logic [7:0] b;
        b = 8'($urandom_range(32, 126));
        if (b == CH_DQUOTE || b == CH_SQUOTE || b == CH_SLASH || b == CH_STAR) begin
            b = 8'h61;
        end
        if ($urandom_range(0, 9) == 0) begin
            b = CH_NL;
        end
        return b;
    endfunction

    task automatic push_literal(input logic [7:0] quote);
        logic [7:0] b;
        frame_q.push_back(quote);
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 5))
                0: begin
                    frame_q.push_back(CH_BSLASH);
                    frame_q.push_back($urandom_range(0, 1) ? quote : 8'($urandom_range(0, 255)));
                end
                1: frame_q.push_back(CH_NL);
                default: begin
                    b = 8'($urandom_range(0, 255));
                    if (b == quote || b == CH_BSLASH) begin
                        b = 8'h61;
                    end
                    frame_q.push_back(b);
                end
            endcase
        end
        frame_q.push_back(quote);
    endtask

    task automatic push_comment(input bit block);
        logic [7:0] b;
        frame_q.push_back(CH_SLASH);
        frame_q.push_back(block ? CH_STAR : CH_SLASH);
        repeat ($urandom_range(0, 10)) begin
            b = 8'($urandom_range(0, 255));
            if (block && $urandom_range(0, 3) == 0) begin
                b = CH_STAR;
            end else if (block && $urandom_range(0, 6) == 0) begin
                b = CH_SLASH;
            end else if (!block && b == CH_NL) begin
                b = 8'h23;
            end
            frame_q.push_back(b);
        end
        if (block) begin
            frame_q.push_back(CH_STAR);
            frame_q.push_back(CH_SLASH);
        end else begin
            frame_q.push_back(CH_NL);
        end
    endtask

    task automatic build_frame();
        int cut;
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(1, 6)) frame_q.push_back(code_char());
                3: push_literal(CH_DQUOTE);
                4: push_literal(CH_SQUOTE);
                5: push_comment(1'b0);
                6: push_comment(1'b1);
                7: begin
                    frame_q.push_back(CH_SLASH);
                    frame_q.push_back(code_char());
                end
                8: repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
                default: begin
                    frame_q.push_back(CH_SLASH);
                    frame_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        // Some frames end in the middle of a comment or a literal.
        if ($urandom_range(0, 9) == 0 && frame_q.size() > 1) begin
            cut = $urandom_range(1, frame_q.size() - 1);
            repeat (cut) void'(frame_q.pop_back());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        frame_q = {8'h00, 8'hFF, CH_SLASH, 8'h78, CH_SLASH, CH_DQUOTE, CH_BSLASH, CH_DQUOTE,
                   CH_NL, CH_DQUOTE, CH_SLASH, CH_SLASH, 8'h7A, CH_NL, CH_SLASH, CH_STAR,
                   CH_SLASH, CH_STAR, CH_SLASH, CH_SQUOTE, CH_BSLASH, CH_SQUOTE, CH_SQUOTE,
                   CH_SLASH};
        send_frame(1'b1);
        frame_q = {CH_SLASH, CH_STAR, 8'h71};
        send_frame(1'b1);
        wait_drained();

        // The output side stalls for a long time while the input keeps offering items.
        hold_requests++;
        wait (holds_started == hold_requests);
        repeat (20) begin
            frame_q.push_back(CH_SLASH);
            frame_q.push_back(code_char());
        end
        send_frame(1'b0);
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            build_frame();
            if (frames_sent == 150) begin
                hold_requests++;
            end
            send_frame($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 49) == 0) begin
                wait_drained();
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d source bytes in %0d frames, checked %0d kept bytes, %0d failures",
                 items_sent, frames_sent, checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
